// ----- hdl/obbq_pkg.sv -----
// obbq_pkg: shared types, constants and saturation helpers for the oriented box query core
// no dependencies; used by every module in hdl

package obbq_pkg;

    // query function codes
    localparam logic [1:0] FUNC_SUPPORT = 2'd0;
    localparam logic [1:0] FUNC_BBOX    = 2'd1;
    localparam logic [1:0] FUNC_FACE    = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_X = 2'd0;
    localparam logic [1:0] CFG_HALF_Y = 2'd1;
    localparam logic [1:0] CFG_HALF_Z = 2'd2;

    localparam logic [30:0] HALF_RESET = 31'd65536;

    // queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // one classified query, ready for the back part
    typedef struct packed {
        logic [1:0]       func;
        logic [8:0][31:0] rot;    // row major, Q2.30
        logic [2:0][31:0] pos;
        logic [2:0]       neg;    // sign of local direction per axis
        logic [1:0]       axis;   // dominant local axis
    } obbq_desc_t;

    // clamp a wide signed sum to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [36:0] v);
        logic [31:0] r;
        if (v > 37'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -37'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // clamp a wide signed sum to [0, 2^31-1]
    function automatic logic [30:0] satu31(input logic signed [36:0] v);
        logic [30:0] r;
        if (v > 37'sh0_7FFF_FFFF)
            r = 31'h7FFF_FFFF;
        else if (v < 37'sd0)
            r = 31'd0;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

// ----- hdl/obbq_front.sv -----
// obbq_front: accepts queries, builds the rotation matrix and classifies the local direction
// depends on obbq_pkg

module obbq_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [319:0]         in_data,
    input  logic [1:0]           in_func,
    input  logic                 q_full,
    output logic                 q_push,
    output obbq_pkg::obbq_desc_t q_desc
);

    logic                       en;
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic [1:0]                 f1_reg, f2_reg, f3_reg;
    logic [8:0][33:0]           qp_reg, qp_next;
    logic [2:0][31:0]           d1_reg, d2_reg, p1_reg, p2_reg, p3_reg;
    logic [8:0][31:0]           r2_reg, r2_next, r3_reg;
    logic [8:0][33:0]           lp_reg, lp_next;
    obbq_pkg::obbq_desc_t       desc_reg, desc_next;
    logic [3:0][31:0]           quat;

    assign quat[0] = in_data[223:192];
    assign quat[1] = in_data[255:224];
    assign quat[2] = in_data[287:256];
    assign quat[3] = in_data[319:288];

    // whole front advances unless the head item cannot enter the queue
    assign en       = !v4_reg || !q_full;
    assign in_ready = en;
    assign q_push   = v4_reg && !q_full;
    assign q_desc   = desc_reg;

    // quaternion products: xx yy zz xy xz yz wx wy wz
    always_comb
    begin
        logic signed [63:0] m [9];
        m[0] = $signed(quat[1]) * $signed(quat[1]);
        m[1] = $signed(quat[2]) * $signed(quat[2]);
        m[2] = $signed(quat[3]) * $signed(quat[3]);
        m[3] = $signed(quat[1]) * $signed(quat[2]);
        m[4] = $signed(quat[1]) * $signed(quat[3]);
        m[5] = $signed(quat[2]) * $signed(quat[3]);
        m[6] = $signed(quat[0]) * $signed(quat[1]);
        m[7] = $signed(quat[0]) * $signed(quat[2]);
        m[8] = $signed(quat[0]) * $signed(quat[3]);
        for (int i = 0; i < 9; i++)
            qp_next[i] = m[i][63:30];
    end

    // rotation matrix entries, saturated to Q2.30
    always_comb
    begin
        logic signed [36:0] one;
        logic signed [36:0] e [9];
        logic signed [36:0] q [9];
        one = 37'sd1073741824;
        for (int i = 0; i < 9; i++)
            q[i] = 37'($signed(qp_reg[i]));
        e[0] = one - 2 * (q[1] + q[2]);
        e[1] = 2 * (q[3] - q[8]);
        e[2] = 2 * (q[4] + q[7]);
        e[3] = 2 * (q[3] + q[8]);
        e[4] = one - 2 * (q[0] + q[2]);
        e[5] = 2 * (q[5] - q[6]);
        e[6] = 2 * (q[4] - q[7]);
        e[7] = 2 * (q[5] + q[6]);
        e[8] = one - 2 * (q[0] + q[1]);
        for (int i = 0; i < 9; i++)
            r2_next[i] = obbq_pkg::sat32(e[i]);
    end

    // terms of the local direction: loc[i] gathers R[j][i] * d[j]
    always_comb
    begin
        logic signed [63:0] m;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                m = $signed(r2_reg[j*3+i]) * $signed(d2_reg[j]);
                lp_next[i*3+j] = m[63:30];
            end
    end

    // local direction signs and dominant axis
    always_comb
    begin
        logic signed [35:0] loc [3];
        logic [35:0]        mag [3];
        for (int i = 0; i < 3; i++)
        begin
            loc[i] = 36'($signed(lp_reg[i*3])) + 36'($signed(lp_reg[i*3+1]))
                   + 36'($signed(lp_reg[i*3+2]));
            mag[i] = loc[i][35] ? 36'(-loc[i]) : 36'(loc[i]);
        end
        desc_next.func = f3_reg;
        desc_next.rot  = r3_reg;
        desc_next.pos  = p3_reg;
        for (int i = 0; i < 3; i++)
            desc_next.neg[i] = loc[i][35];
        if (mag[1] > mag[0] && mag[1] > mag[2])
            desc_next.axis = 2'd1;
        else if (mag[2] > mag[0] && mag[2] > mag[1])
            desc_next.axis = 2'd2;
        else
            desc_next.axis = 2'd0;
    end

    // pipeline valid bits; unknown codes are dropped on entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid && (in_func != obbq_pkg::FUNC_NONE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qp_reg   <= qp_next;
            f1_reg   <= in_func;
            d1_reg   <= in_data[95:0];
            p1_reg   <= in_data[191:96];
            r2_reg   <= r2_next;
            f2_reg   <= f1_reg;
            d2_reg   <= d1_reg;
            p2_reg   <= p1_reg;
            lp_reg   <= lp_next;
            r3_reg   <= r2_reg;
            f3_reg   <= f2_reg;
            p3_reg   <= p2_reg;
            desc_reg <= desc_next;
        end
    end

endmodule

// ----- hdl/obbq_queue.sv -----
// obbq_queue: short request queue between front and back
// depends on obbq_pkg

module obbq_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  obbq_pkg::obbq_desc_t push_desc,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output obbq_pkg::obbq_desc_t head
);

    obbq_pkg::obbq_desc_t                 mem_reg [obbq_pkg::QueueDepth];
    logic [obbq_pkg::QueuePtrW-1:0]       wp_reg, rp_reg;
    logic [obbq_pkg::QueuePtrW:0]         cnt_reg;

    assign full      = (cnt_reg == (obbq_pkg::QueuePtrW+1)'(obbq_pkg::QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_desc;
    end

endmodule

// ----- hdl/obbq_back.sv -----
// obbq_back: expands each request into result beats and maps corners to world space
// depends on obbq_pkg

module obbq_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  obbq_pkg::obbq_desc_t q_head,
    output logic                 q_pop,
    input  logic [2:0][30:0]     half,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [191:0]         out_data,
    output logic                 out_last
);

    logic                  en;
    logic [1:0]            k_reg;
    logic                  beat_last;
    logic [2:0]            neg;
    logic [8:0][34:0]      pr_next, pr_reg;
    logic [2:0][31:0]      pos_reg;
    logic [1:0]            f_reg, idx_reg;
    logic                  l_reg, b1v_reg;
    logic                  ov_reg;
    logic [191:0]          od_reg, od_next;
    logic                  ol_reg;

    assign en        = !ov_reg || out_ready;
    assign beat_last = (q_head.func != obbq_pkg::FUNC_FACE) || (k_reg == 2'd3);
    assign q_pop     = en && q_valid && beat_last;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

    // corner signs for this beat; face order (+,+) (+,-) (-,-) (-,+) on (u,v)
    always_comb
    begin
        neg = q_head.neg;
        if (q_head.func == obbq_pkg::FUNC_FACE)
        begin
            case (q_head.axis)
                2'd1:
                begin
                    neg[2] = k_reg[1];
                    neg[0] = k_reg[1] ^ k_reg[0];
                end
                2'd2:
                begin
                    neg[0] = k_reg[1];
                    neg[1] = k_reg[1] ^ k_reg[0];
                end
                default:
                begin
                    neg[1] = k_reg[1];
                    neg[2] = k_reg[1] ^ k_reg[0];
                end
            endcase
        end
    end

    // nine products: R*corner, or |R|*half for the bounding box
    always_comb
    begin
        logic signed [32:0] a;
        logic signed [31:0] b;
        logic signed [64:0] m;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                a = 33'($signed(q_head.rot[i*3+j]));
                b = $signed({1'b0, half[j]});
                if (q_head.func == obbq_pkg::FUNC_BBOX)
                begin
                    if (a < 0)
                        a = -a;
                end
                else if (neg[j])
                    b = -b;
                m = a * b;
                pr_next[i*3+j] = m[64:30];
            end
    end

    // sums and saturation into the output word
    always_comb
    begin
        logic signed [36:0] s;
        od_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            s = 37'($signed(pr_reg[i*3])) + 37'($signed(pr_reg[i*3+1]))
              + 37'($signed(pr_reg[i*3+2]));
            if (f_reg == obbq_pkg::FUNC_BBOX)
            begin
                od_next[i*32 +: 32]      = pos_reg[i];
                od_next[96 + i*31 +: 31] = obbq_pkg::satu31(s);
            end
            else
                od_next[i*32 +: 32] = obbq_pkg::sat32(s + 37'($signed(pos_reg[i])));
        end
        od_next[190:189] = idx_reg;
    end

    // beat counter and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= 2'd0;
            b1v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            b1v_reg <= q_valid;
            ov_reg  <= b1v_reg;
            if (q_valid)
                k_reg <= beat_last ? 2'd0 : k_reg + 2'd1;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg  <= pr_next;
            pos_reg <= q_head.pos;
            f_reg   <= q_head.func;
            idx_reg <= (q_head.func == obbq_pkg::FUNC_FACE) ? k_reg : 2'd0;
            l_reg   <= beat_last;
            od_reg  <= od_next;
            ol_reg  <= l_reg;
        end
    end

endmodule

// ----- hdl/oriented_box_geometry_query_core.sv -----
// oriented_box_geometry_query_core: top level of the oriented box support / bound / face query
// depends on obbq_pkg, obbq_front, obbq_queue, obbq_back
//
// channel   dir  width  contents
// s_axis    in   320+2  one query request: direction, position, quaternion; tuser = func
// m_axis    out  192+1  one result beat: point, extents, vertex index; tlast = last
// cfg       in   2+31   half size register writes
//
// a support or bounding box request gives one beat, a face request four beats
// one request a cycle is accepted unless the front stalls; a face request holds the back for its four beats
// a request passes four front stages, the queue and two back stages before its first beat
// the back stalls on m_axis_tready and the front on a full four-entry queue
// reset clears pipeline valid bits and the queue; half sizes return to 1.0

module oriented_box_geometry_query_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [319:0]  s_axis_tdata,   // dir_x dir_y dir_z pos_x pos_y pos_z quat_w quat_x quat_y quat_z
    input  logic [1:0]    s_axis_tuser,   // func
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,   // point_x point_y point_z extent_x extent_y extent_z vertex_index pad
    output logic          m_axis_tlast,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_wdata
);

    logic [2:0][30:0]      half_reg;
    logic                  q_full, q_push, q_pop, q_valid;
    obbq_pkg::obbq_desc_t  push_desc, head;

    // half size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= obbq_pkg::HALF_RESET;
            half_reg[1] <= obbq_pkg::HALF_RESET;
            half_reg[2] <= obbq_pkg::HALF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                obbq_pkg::CFG_HALF_X: half_reg[0] <= cfg_wdata;
                obbq_pkg::CFG_HALF_Y: half_reg[1] <= cfg_wdata;
                obbq_pkg::CFG_HALF_Z: half_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    obbq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_func  (s_axis_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (push_desc)
    );

    obbq_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head)
    );

    obbq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (head),
        .q_pop     (q_pop),
        .half      (half_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
